// ----- design/icdf_pkg.sv -----
// Shared widths, register indexes and unit interface types for the inverse-CDF sampler.
`timescale 1ns / 1ps

package icdf_pkg;

  // Default sizing of the block.
  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int DEF_DRAW_BITS     = 32;

  // Fixed field widths.
  localparam int ENTRY_W     = 33;   // Q1.32 table entry
  localparam int INDEX_W     = 12;   // load index and bin number ports
  localparam int CDF_SHIFT   = 16;   // table entries are compared in Q.48
  localparam int KSI_W       = 48;   // draw aligned to Q.48
  localparam int SUB_W       = 51;   // shared subtractor width
  localparam int MUL_AW      = 33;   // signed multiplier operand A
  localparam int MUL_BW      = 34;   // signed multiplier operand B
  localparam int MUL_PW      = MUL_AW + MUL_BW;
  localparam int DIV_STEPS   = 32;   // quotient bits of the fraction
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_T_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_P2 = 2'd2;
  localparam logic [31:0] INV_P2_RESET = 32'h0100_0000;

  // Operands presented to the shared arithmetic unit.
  typedef struct packed {
    logic [SUB_W-1:0]  sub_a;
    logic [SUB_W-1:0]  sub_b;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
  } alu_req_t;

  // Results returned by the shared arithmetic unit.
  typedef struct packed {
    logic [SUB_W-1:0]  diff;
    logic [MUL_PW-1:0] prod;
  } alu_rsp_t;

endpackage

// ----- design/icdf_table.sv -----
// Cumulative distribution table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module icdf_table #(
  parameter int ENTRIES = icdf_pkg::DEF_TABLE_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [icdf_pkg::ENTRY_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [icdf_pkg::ENTRY_W-1:0] rd_data
);

  logic [icdf_pkg::ENTRY_W-1:0] mem [ENTRIES];

  // Write from load transactions.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, data in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/icdf_alu.sv -----
// Shared arithmetic unit: a wide subtractor for compares and division, and a registered multiplier.
`timescale 1ns / 1ps

module icdf_alu (
  input  logic               clk,
  input  icdf_pkg::alu_req_t req,
  output icdf_pkg::alu_rsp_t rsp
);

  logic signed [icdf_pkg::MUL_PW-1:0] prod;

  // The difference is used in the same cycle; its sign bit gives the compare.
  assign rsp.diff = req.sub_a - req.sub_b;

  // Signed product, registered before any further use.
  always_ff @(posedge clk) begin
    prod <= $signed(req.mul_a) * $signed(req.mul_b);
  end

  assign rsp.prod = prod;

endmodule

// ----- design/inverse_cdf_table_sampler_top.sv -----
// Top level of the inverse-CDF table sampler: sequencer, registers and result stage.
`timescale 1ns / 1ps
//
// Inverse transform sampler over a tabulated cumulative distribution.
// Request channel (req_valid / req_stall): mode 0 writes cdf_value into
// entry entry_index (indexes beyond the table are dropped) and gives no
// result. Mode 1 draws one sample from uniform_draw.
// Result channel (res_valid / res_stall): t_value, cos_theta, bin_number and
// flat_bin, one transaction per sample.
// A sample walks a binary search through the table memory at one probe per
// cycle, then fetch, rounding and cosine steps and a restoring division, all on
// one shared subtractor and one shared multiplier; a flat bin or an out-of-bin
// draw skips the division.
// req_stall is high from acceptance of a sample until its result is loaded.
// The result register holds while res_stall is high; a new request is taken
// meanwhile, and a following sample waits at its last step until it is free.
// Reset (rst, synchronous) empties the result register, returns the sequencer
// to idle and loads the configuration reset values; the table is not cleared
// and every entry must be loaded before a sample reads it.
// Configuration writes (cfg_valid / cfg_ready) are always taken.

module inverse_cdf_table_sampler_top #(
  parameter int TABLE_ENTRIES = icdf_pkg::DEF_TABLE_ENTRIES,
  parameter int DRAW_BITS     = icdf_pkg::DEF_DRAW_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  // Request channel.
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            mode,
  input  logic [icdf_pkg::INDEX_W-1:0]    entry_index,
  input  logic [icdf_pkg::ENTRY_W-1:0]    cdf_value,
  input  logic [31:0]                     uniform_draw,
  // Result channel.
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic signed [31:0]              t_value,
  output logic signed [31:0]              cos_theta,
  output logic [icdf_pkg::INDEX_W-1:0]    bin_number,
  output logic                            flat_bin
);

  localparam int AW      = $clog2(TABLE_ENTRIES);
  localparam int DW      = (DRAW_BITS < 32) ? DRAW_BITS : 32;
  localparam int SW      = icdf_pkg::SUB_W;
  localparam int PW      = icdf_pkg::MUL_PW;
  localparam int TW      = 56;   // t accumulator
  localparam int CW      = 48;   // rounded cosine product
  localparam logic [AW-1:0] HI0  = AW'(TABLE_ENTRIES - 1);
  localparam logic [AW-1:0] MID0 = AW'((TABLE_ENTRIES - 1) / 2);
  localparam logic [31:0]   DRAW_MASK = 32'((64'd1 << DW) - 64'd1);
  localparam logic signed [TW-1:0] T_SAT_HI = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] T_SAT_LO = -T_SAT_HI - TW'(64'sd1);
  localparam logic signed [CW-1:0] C_ONE    = CW'(64'sd1073741824);
  localparam logic signed [PW-1:0] D_HALF   = PW'(64'sd2147483648);
  localparam logic signed [PW-1:0] C_HALF   = PW'(64'sd131072);
  localparam logic [icdf_pkg::ENTRY_W-1:0] FRAC_ONE = 33'h1_0000_0000;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SEARCH  = 4'd1;
  localparam logic [3:0] ST_RD_HI   = 4'd2;
  localparam logic [3:0] ST_LOAD_HI = 4'd3;
  localparam logic [3:0] ST_DEN     = 4'd4;
  localparam logic [3:0] ST_SIGN    = 4'd5;
  localparam logic [3:0] ST_CMP1    = 4'd6;
  localparam logic [3:0] ST_DIV     = 4'd7;
  localparam logic [3:0] ST_MUL_D   = 4'd8;
  localparam logic [3:0] ST_ROUND_D = 4'd9;
  localparam logic [3:0] ST_ADD_D   = 4'd10;
  localparam logic [3:0] ST_SAT     = 4'd11;
  localparam logic [3:0] ST_MUL_C   = 4'd12;
  localparam logic [3:0] ST_COS1    = 4'd13;
  localparam logic [3:0] ST_COS2    = 4'd14;

  logic [3:0] state;

  // Configuration registers.
  logic signed [31:0] t_min;
  logic signed [31:0] t_step;
  logic [31:0]        inv_p2;

  // Working registers.
  logic [icdf_pkg::KSI_W-1:0]   ksi;
  logic [AW-1:0]                lo;
  logic [AW-1:0]                hi;
  logic [AW-1:0]                mid;
  logic [icdf_pkg::ENTRY_W-1:0] yl;
  logic [icdf_pkg::ENTRY_W-1:0] ym;
  logic [SW-1:0]                num;
  logic [SW-1:0]                den;
  logic [SW-1:0]                ad;
  logic [SW-1:0]                rem;
  logic [31:0]                  quo;
  logic [icdf_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [icdf_pkg::ENTRY_W-1:0] fr;
  logic                         flat;
  logic signed [TW-1:0]         t_acc;
  logic signed [TW-1:0]         d_val;
  logic signed [31:0]           t_sat;
  logic signed [CW-1:0]         c_rnd;

  // Interconnect.
  icdf_pkg::alu_req_t           alu_req;
  icdf_pkg::alu_rsp_t           alu_rsp;
  logic [AW-1:0]                rd_addr;
  logic [icdf_pkg::ENTRY_W-1:0] rd_data;
  logic                         wr_en;
  logic [31:0]                  idx_wide;
  logic                         req_take;
  logic [icdf_pkg::KSI_W-1:0]   draw_ksi;

  // Search step and arithmetic helpers.
  logic                         probe_gt;
  logic [AW-1:0]                lo_next;
  logic [AW-1:0]                hi_next;
  logic [AW:0]                  mid_sum;
  logic                         search_done;
  logic [SW-1:0]                rem_dbl;
  logic [31:0]                  quo_next;
  logic signed [PW-1:0]         d_rnd;
  logic signed [PW-1:0]         c_prod_rnd;
  logic signed [CW-1:0]         c_sum;
  logic signed [31:0]           c_clamp;
  logic signed [31:0]           t_clamp;
  logic                         res_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  // Load transactions write the table directly; indexes past the end are dropped.
  assign idx_wide = 32'(entry_index);
  assign wr_en    = req_take && !mode && (idx_wide < 32'(TABLE_ENTRIES));

  // Draw aligned to Q.48.
  assign draw_ksi = icdf_pkg::KSI_W'({16'b0, uniform_draw & DRAW_MASK}) << (48 - DRAW_BITS);

  icdf_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_wide[AW-1:0]),
    .wr_data (cdf_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  icdf_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // One search probe: the entry at mid is compared against the draw.
  always_comb begin
    probe_gt    = alu_rsp.diff[SW-1];
    lo_next     = probe_gt ? lo : mid;
    hi_next     = probe_gt ? mid : hi;
    mid_sum     = {1'b0, lo_next} + {1'b0, hi_next};
    search_done = (({1'b0, lo_next} + (AW+1)'(1)) == {1'b0, hi_next});
  end

  // Table read address.
  always_comb begin
    unique case (state)
      ST_SEARCH: rd_addr = search_done ? lo_next : mid_sum[AW:1];
      ST_RD_HI:  rd_addr = hi;
      default:   rd_addr = MID0;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.sub_a = '0;
    alu_req.sub_b = '0;
    alu_req.mul_a = {t_step[31], t_step};
    alu_req.mul_b = '0;
    unique case (state)
      ST_SEARCH: begin
        alu_req.sub_a = SW'(ksi);
        alu_req.sub_b = SW'({rd_data, 16'b0});
      end
      ST_LOAD_HI: begin
        alu_req.sub_a = SW'(ksi);
        alu_req.sub_b = SW'({yl, 16'b0});
        alu_req.mul_b = icdf_pkg::MUL_BW'(lo);
      end
      ST_DEN: begin
        alu_req.sub_a = SW'({ym, 16'b0});
        alu_req.sub_b = SW'({yl, 16'b0});
      end
      ST_CMP1: begin
        alu_req.sub_a = num;
        alu_req.sub_b = ad;
      end
      ST_DIV: begin
        alu_req.sub_a = rem_dbl;
        alu_req.sub_b = ad;
      end
      ST_MUL_D: begin
        alu_req.mul_b = {1'b0, fr};
      end
      ST_MUL_C: begin
        alu_req.mul_a = {t_sat[31], t_sat};
        alu_req.mul_b = {2'b0, inv_p2};
      end
      default: begin
        alu_req.sub_a = '0;
      end
    endcase
  end

  // Division step, rounding and clamping helpers.
  always_comb begin
    rem_dbl    = {rem[SW-2:0], 1'b0};
    quo_next   = {quo[30:0], !alu_rsp.diff[SW-1]};
    d_rnd      = $signed(alu_rsp.prod) + D_HALF;
    c_prod_rnd = $signed(alu_rsp.prod) + C_HALF;
    c_sum      = c_rnd + C_ONE;
    if (c_sum > C_ONE) begin
      c_clamp = 32'(C_ONE);
    end else if (c_sum < -C_ONE) begin
      c_clamp = 32'(-C_ONE);
    end else begin
      c_clamp = c_sum[31:0];
    end
    if (t_acc > T_SAT_HI) begin
      t_clamp = 32'h7FFF_FFFF;
    end else if (t_acc < T_SAT_LO) begin
      t_clamp = 32'h8000_0000;
    end else begin
      t_clamp = t_acc[31:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_min  <= '0;
      t_step <= '0;
      inv_p2 <= icdf_pkg::INV_P2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        icdf_pkg::REG_T_MIN:  t_min  <= cfg_data;
        icdf_pkg::REG_T_STEP: t_step <= cfg_data;
        icdf_pkg::REG_INV_P2: inv_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take && mode) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (search_done) begin
            state <= ST_RD_HI;
          end
        end
        ST_RD_HI:   state <= ST_LOAD_HI;
        ST_LOAD_HI: state <= ST_DEN;
        ST_DEN:     state <= ST_SIGN;
        ST_SIGN: begin
          if (flat || (num == '0) || (num[SW-1] ^ den[SW-1])) begin
            state <= ST_SAT;
          end else begin
            state <= ST_CMP1;
          end
        end
        ST_CMP1: begin
          state <= alu_rsp.diff[SW-1] ? ST_DIV : ST_MUL_D;
        end
        ST_DIV: begin
          if (div_cnt == icdf_pkg::DIV_CNT_W'(icdf_pkg::DIV_STEPS - 1)) begin
            state <= ST_MUL_D;
          end
        end
        ST_MUL_D:   state <= ST_ROUND_D;
        ST_ROUND_D: state <= ST_ADD_D;
        ST_ADD_D:   state <= ST_SAT;
        ST_SAT:     state <= ST_MUL_C;
        ST_MUL_C:   state <= ST_COS1;
        ST_COS1:    state <= ST_COS2;
        ST_COS2: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        ksi <= draw_ksi;
        lo  <= '0;
        hi  <= HI0;
        mid <= MID0;
      end
      ST_SEARCH: begin
        lo  <= lo_next;
        hi  <= hi_next;
        mid <= mid_sum[AW:1];
      end
      ST_RD_HI: begin
        yl <= rd_data;
      end
      ST_LOAD_HI: begin
        ym  <= rd_data;
        num <= alu_rsp.diff;
      end
      ST_DEN: begin
        den   <= alu_rsp.diff;
        flat  <= (ym == yl);
        t_acc <= TW'(t_min) + TW'($signed(alu_rsp.prod));
      end
      ST_SIGN: begin
        // Magnitudes for the division; a fraction of zero leaves t at the bin edge.
        fr  <= '0;
        num <= num[SW-1] ? -num : num;
        ad  <= den[SW-1] ? -den : den;
      end
      ST_CMP1: begin
        fr      <= FRAC_ONE;
        rem     <= num;
        quo     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= alu_rsp.diff[SW-1] ? rem_dbl : alu_rsp.diff;
        quo     <= quo_next;
        div_cnt <= div_cnt + icdf_pkg::DIV_CNT_W'(1);
        fr      <= {1'b0, quo_next};
      end
      ST_ROUND_D: begin
        d_val <= TW'(d_rnd >>> 32);
      end
      ST_ADD_D: begin
        t_acc <= t_acc + d_val;
      end
      ST_SAT: begin
        t_sat <= t_clamp;
      end
      ST_COS1: begin
        c_rnd <= CW'(c_prod_rnd >>> 18);
      end
      ST_COS2: begin
        if (res_free) begin
          t_value    <= t_sat;
          cos_theta  <= c_clamp;
          bin_number <= 32'(lo) >> 0 == 32'(lo) ? icdf_pkg::INDEX_W'(32'(lo)) : '0;
          flat_bin   <= flat;
        end
      end
      default: begin
        d_val <= d_val;
      end
    endcase
  end

  // The search interval never collapses below one bin.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((32'(lo) + 32'd1) < 32'(hi)))
    else $error("search interval collapsed");

  // The partial remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < ad))
    else $error("division remainder not below divisor");

  // The interpolation fraction never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_D) |-> (fr <= FRAC_ONE))
    else $error("interpolation fraction above one");

  // A result appears only from the final step of a sample.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_COS2))
    else $error("result raised outside the final step");

endmodule

// ----- tb/icdf_tb_pkg.sv -----
// Request mode codes shared by the sampler checker and the sampler testbench.
`timescale 1ns / 1ps

package icdf_tb_pkg;

  // Meaning of the mode field of a request transaction.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

endpackage

// ----- tb/icdf_sample_checker.sv -----
// Checker that mirrors the sampler table and registers and compares every result transaction.
`timescale 1ns / 1ps

module icdf_sample_checker #(
  parameter int TABLE_ENTRIES = icdf_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [icdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic                           mode,
  input  logic [icdf_pkg::INDEX_W-1:0]   entry_index,
  input  logic [icdf_pkg::ENTRY_W-1:0]   cdf_value,
  input  logic [31:0]                    uniform_draw,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic signed [31:0]             t_value,
  input  logic signed [31:0]             cos_theta,
  input  logic [icdf_pkg::INDEX_W-1:0]   bin_number,
  input  logic                           flat_bin,
  output int                             pending,
  output int                             failures
);
  import icdf_pkg::*;
  import icdf_tb_pkg::*;

  localparam longint T_SAT_LO   = -64'sd2147483648;
  localparam longint T_SAT_HI   = 64'sd2147483647;
  localparam longint COS_ONE    = 64'sd1073741824;
  localparam longint ROUND_FRAC = 64'sd2147483648;
  localparam longint ROUND_COS  = 64'sd131072;
  localparam logic [32:0] FRAC_ONE = 33'h1_0000_0000;

  typedef struct packed {
    logic [31:0]        t_value;
    logic [31:0]        cos_theta;
    logic [INDEX_W-1:0] bin_number;
    logic               flat_bin;
  } sample_result_t;

  logic [ENTRY_W-1:0] cdf_mirror [TABLE_ENTRIES];
  logic signed [31:0] t_min_q;
  logic signed [31:0] t_step_q;
  logic [31:0]        inv_p2_q;
  sample_result_t     expected_samples [$];
  int                 mismatch_count = 0;

  // Position inside the bin as num/den in Q1.32, truncated and clamped to [0, 1].
  function automatic logic [32:0] bin_fraction(longint num, longint den);
    longint unsigned mag_n;
    longint unsigned mag_d;
    longint unsigned rem;
    logic [32:0]     quo;
    if (num == 0 || (num < 0 && den > 0) || (num > 0 && den < 0)) return '0;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    if (mag_n >= mag_d) return FRAC_ONE;
    rem = mag_n;
    quo = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= mag_d) begin
        rem = rem - mag_d;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Search the mirrored table for the bin of a draw, interpolate and form the cosine.
  function automatic sample_result_t predict_sample(logic [31:0] draw);
    int             lo;
    int             hi;
    int             mid;
    logic [48:0]    draw_q48;
    longint         y_lo;
    longint         y_hi;
    longint         t_left;
    longint         t_pos;
    longint         delta;
    longint         cos_q30;
    logic [32:0]    frac;
    sample_result_t res;
    draw_q48 = {1'b0, draw, 16'h0000};
    lo = 0;
    hi = TABLE_ENTRIES - 1;
    while (lo + 1 != hi) begin
      mid = (lo + hi) / 2;
      if ({cdf_mirror[mid], 16'h0000} > draw_q48) hi = mid;
      else lo = mid;
    end
    y_lo = longint'({cdf_mirror[lo], 16'h0000});
    y_hi = longint'({cdf_mirror[hi], 16'h0000});
    t_left = longint'(t_min_q) + longint'(lo) * longint'(t_step_q);
    res.flat_bin = (y_hi == y_lo);
    if (res.flat_bin) begin
      t_pos = t_left;
    end else begin
      frac = bin_fraction(longint'(draw_q48) - y_lo, y_hi - y_lo);
      delta = (longint'(t_step_q) * longint'(frac) + ROUND_FRAC) >>> 32;
      t_pos = t_left + delta;
    end
    if (t_pos < T_SAT_LO) t_pos = T_SAT_LO;
    else if (t_pos > T_SAT_HI) t_pos = T_SAT_HI;
    // The cosine is taken from the saturated value.
    cos_q30 = ((t_pos * longint'(inv_p2_q) + ROUND_COS) >>> 18) + COS_ONE;
    if (cos_q30 < -COS_ONE) cos_q30 = -COS_ONE;
    else if (cos_q30 > COS_ONE) cos_q30 = COS_ONE;
    res.t_value    = t_pos[31:0];
    res.cos_theta  = cos_q30[31:0];
    res.bin_number = lo[INDEX_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Follow the three channels at each rising edge; results are checked before new samples
  // are queued so that a result is never matched against a sample taken at the same edge.
  always @(posedge clk) begin
    sample_result_t want;
    if (rst) begin
      t_min_q  = '0;
      t_step_q = '0;
      inv_p2_q = INV_P2_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_T_MIN:  t_min_q  = cfg_data;
          REG_T_STEP: t_step_q = cfg_data;
          REG_INV_P2: inv_p2_q = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (expected_samples.size() == 0) begin
          $error("result transaction with no sample outstanding: t_value %0d", t_value);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          check_field("t_value", $signed(want.t_value), t_value);
          check_field("cos_theta", $signed(want.cos_theta), cos_theta);
          check_field("bin_number", want.bin_number, bin_number);
          check_field("flat_bin", want.flat_bin, flat_bin);
        end
      end
      if (req_valid && !req_stall) begin
        if (mode == MODE_LOAD) begin
          if (entry_index < TABLE_ENTRIES) cdf_mirror[entry_index] = cdf_value;
        end else begin
          expected_samples.push_back(predict_sample(uniform_draw));
        end
      end
    end
    pending  <= expected_samples.size();
    failures <= mismatch_count;
  end

endmodule

// ----- tb/tb_inverse_cdf_table_sampler_top.sv -----
// Testbench top for the inverse-CDF table sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_inverse_cdf_table_sampler_top;
  import icdf_pkg::*;
  import icdf_tb_pkg::*;

  localparam int TABLE_ENTRIES   = DEF_TABLE_ENTRIES;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_ROUNDS   = 8;
  localparam int ITEMS_PER_ROUND = 70;
  localparam logic [ENTRY_W-1:0] CDF_FULL = 33'h1_0000_0000;

  typedef enum int {SHAPE_LINEAR, SHAPE_STAIRS, SHAPE_PALETTE} table_shape_e;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 req_valid;
  logic                 req_stall;
  logic                 mode;
  logic [INDEX_W-1:0]   entry_index;
  logic [ENTRY_W-1:0]   cdf_value;
  logic [31:0]          uniform_draw;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic signed [31:0]   t_value;
  logic signed [31:0]   cos_theta;
  logic [INDEX_W-1:0]   bin_number;
  logic                 flat_bin;
  int                   pending;
  int                   failures;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   hold_requests = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  int                   cycle_count = 0;
  logic [ENTRY_W-1:0]   shadow_cdf [TABLE_ENTRIES];

  inverse_cdf_table_sampler_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .mode(mode), .entry_index(entry_index),
    .cdf_value(cdf_value), .uniform_draw(uniform_draw),
    .res_valid(res_valid), .res_stall(res_stall), .t_value(t_value), .cos_theta(cos_theta),
    .bin_number(bin_number), .flat_bin(flat_bin)
  );

  icdf_sample_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) sample_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .mode(mode), .entry_index(entry_index),
    .cdf_value(cdf_value), .uniform_draw(uniform_draw),
    .res_valid(res_valid), .res_stall(res_stall), .t_value(t_value), .cos_theta(cos_theta),
    .bin_number(bin_number), .flat_bin(flat_bin),
    .pending(pending), .failures(failures)
  );

  // A 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result receiver: random stalling, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      res_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one request transaction, after random idle cycles, and wait for its acceptance.
  task automatic send_item(input logic item_mode, input logic [INDEX_W-1:0] idx,
                           input logic [ENTRY_W-1:0] value, input logic [31:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid = 1'b0;
    end
    @(negedge clk);
    req_valid    = 1'b1;
    mode         = item_mode;
    entry_index  = idx;
    cdf_value    = value;
    uniform_draw = draw;
    do @(posedge clk); while (req_stall);
    if (item_mode == MODE_LOAD) shadow_cdf[idx] = value;
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [ENTRY_W-1:0] value);
    send_item(MODE_LOAD, idx, value, $urandom());
  endtask

  task automatic draw_sample(input logic [31:0] draw);
    send_item(MODE_SAMPLE, INDEX_W'($urandom()), ENTRY_W'($urandom()), draw);
  endtask

  // Stop offering requests, wait for every outstanding result, then let the block settle.
  task automatic wait_quiet(input int settle);
    @(negedge clk);
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Program all three registers while the block is idle.
  task automatic write_settings(input logic [31:0] t_min_v, input logic [31:0] t_step_v,
                                input logic [31:0] inv_v);
    logic [CFG_IDX_W-1:0] idx_list [3];
    logic [31:0]          data_list [3];
    idx_list  = '{REG_T_MIN, REG_T_STEP, REG_INV_P2};
    data_list = '{t_min_v, t_step_v, inv_v};
    wait_quiet(SETTLE_CYCLES);
    foreach (idx_list[k]) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = idx_list[k];
      cfg_data  = data_list[k];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write every table entry, so that no sample can read an unwritten one.
  task automatic fill_table(input table_shape_e shape);
    logic [63:0] level;
    level = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      case (shape)
        SHAPE_LINEAR: begin
          level = (64'(i) << 32) / (TABLE_ENTRIES - 1);
        end
        SHAPE_STAIRS: begin
          // Rising with plateaus, starting above zero and usually ending below one.
          if (i == 0) level = $urandom_range(1, 1 << 24);
          else if ($urandom_range(3) != 0) level = level + $urandom_range(0, 1 << 21);
          if (level > CDF_FULL) level = CDF_FULL;
        end
        default: begin
          // Few distinct values in no order: many flat and falling bins.
          level = 64'($urandom_range(0, 4)) << 30;
        end
      endcase
      load_entry(INDEX_W'(i), level[ENTRY_W-1:0]);
    end
  endtask

  // Q8.24 register value: mostly moderate, with the range ends and zero now and then.
  function automatic logic [31:0] pick_q824();
    int unsigned roll;
    logic [31:0] mag;
    roll = $urandom_range(99);
    if (roll < 10) return 32'h8000_0000;
    if (roll < 20) return 32'h7FFF_FFFF;
    if (roll < 25) return 32'h0000_0000;
    mag = $urandom() >> $urandom_range(6, 20);
    return ($urandom_range(1) != 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] pick_inv();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'h0000_0000;
    if (roll < 20) return 32'hFFFF_FFFF;
    if (roll < 35) return INV_P2_RESET;
    return $urandom() >> $urandom_range(0, 12);
  endfunction

  // Draws: some equal to a table entry, some at the ends of the range, the rest uniform.
  function automatic logic [31:0] pick_draw();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return shadow_cdf[$urandom_range(0, TABLE_ENTRIES - 1)][31:0];
    if (roll < 14) return 32'h0000_0000;
    if (roll < 18) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_valid    = 1'b0;
    mode         = MODE_LOAD;
    entry_index  = '0;
    cdf_value    = '0;
    uniform_draw = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Linear table from zero to one, with a moderate mapping.
    write_settings(32'h0100_0000, 32'h0000_1000, INV_P2_RESET);
    fill_table(SHAPE_LINEAR);
    draw_sample(32'h0000_0000);
    draw_sample(32'hFFFF_FFFF);
    draw_sample(32'h8000_0000);
    draw_sample(32'h0000_0001);
    draw_sample(shadow_cdf[1000][31:0]);
    draw_sample(shadow_cdf[TABLE_ENTRIES - 2][31:0]);
    draw_sample($urandom());

    // Flat first bin lying wholly above the draw.
    load_entry(INDEX_W'(0), 33'h0_4000_0000);
    load_entry(INDEX_W'(1), 33'h0_4000_0000);
    draw_sample(32'h0000_0000);
    draw_sample(32'h1000_0000);

    // Flat last bin below the draw, then a draw beyond a rising last bin.
    load_entry(INDEX_W'(TABLE_ENTRIES - 2), 33'h0_8000_0000);
    load_entry(INDEX_W'(TABLE_ENTRIES - 1), 33'h0_8000_0000);
    draw_sample(32'hFFFF_FFFF);
    load_entry(INDEX_W'(TABLE_ENTRIES - 2), 33'h0_7000_0000);
    draw_sample(32'hF000_0000);

    // Falling last bin.
    load_entry(INDEX_W'(TABLE_ENTRIES - 2), 33'h0_9000_0000);
    draw_sample(32'hFFFF_FFFF);

    // Register extremes: saturation both ways and both cosine clamps.
    write_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    draw_sample(32'h8000_0000);
    draw_sample(32'h0000_0000);
    write_settings(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    draw_sample(32'h8000_0000);
    draw_sample(32'hFFFF_FFFF);
    write_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    draw_sample(32'h4000_0000);
    draw_sample($urandom());

    // Random rounds, cycling through four idling patterns, each with its own register setting.
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      case (round % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      write_settings(pick_q824(), pick_q824(), pick_inv());
      if (round % 2 == 0) fill_table(table_shape_e'((round / 2) % 3));
      for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
        // Mid-round: a long receiver hold-off with samples still offered, or a full drain.
        if (round == 0 && n == ITEMS_PER_ROUND / 2) hold_requests++;
        if (round == 1 && n == ITEMS_PER_ROUND / 2) wait_quiet(0);
        if ($urandom_range(99) < 15) begin
          load_entry(INDEX_W'($urandom()),
                     ($urandom_range(9) == 0) ? CDF_FULL : ENTRY_W'($urandom()));
        end else begin
          draw_sample(pick_draw());
        end
      end
    end

    wait_quiet(SETTLE_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
